/* src/gb3_pkg.sv */
package gb3_pkg;

	typedef logic [7:0] chan_t;

	// index 2 is red, 1 is green, 0 is blue
	typedef chan_t [2:0] pix_t;

	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} column_t;

	// one line store entry: the row above and the row of the center pixel
	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} entry_t;

	// neighbor masks and frame marker that travel with a window position
	typedef struct packed {
		logic emit;
		logic top;
		logic bot;
		logic left;
		logic right;
		logic last;
	} ctrl_t;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 13;
	localparam int WIDTH_W     = 11;
	localparam int HEIGHT_W    = 13;
	localparam int IN_ROW_W    = 14;
	localparam int NUM_CHAN    = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

	// floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for every x below 8192
	localparam logic [12:0] RECIP3       = 13'd5462;
	localparam int          RECIP3_SHIFT = 14;

	// divide by 2, 3 or 4 with truncation; x stays below 4096
	function automatic logic [11:0] div_small(input logic [11:0] x, input logic [2:0] d);
		logic [24:0] prod;
		logic [11:0] q;
		prod = {13'd0, x} * {12'd0, RECIP3};
		case (d)
			3'd2:    q = {1'b0, x[11:1]};
			3'd4:    q = {2'b0, x[11:2]};
			default: q = {1'b0, prod[24:RECIP3_SHIFT]};
		endcase
		return q;
	endfunction

	function automatic logic [2:0] divisor(input logic a, input logic b);
		return 3'd2 + {2'b0, a} + {2'b0, b};
	endfunction

endpackage

/* src/gb3_line_store.sv */
module gb3_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output gb3_pkg::entry_t   rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  gb3_pkg::entry_t   wr_data
);

	gb3_pkg::entry_t mem [DEPTH];
	gb3_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read-first; the caller forwards a same-cycle write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/gb3_win_cell.sv */
module gb3_win_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,
	input  gb3_pkg::column_t   col_in,
	output gb3_pkg::column_t   col_out
);

	gb3_pkg::column_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

/* src/gb3_filter.sv */
module gb3_filter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               win_valid,
	input  gb3_pkg::ctrl_t     win_ctrl,
	input  gb3_pkg::column_t   col0,
	input  gb3_pkg::column_t   col1,
	input  gb3_pkg::column_t   col2,
	output logic               res_valid,
	output gb3_pkg::pix_t      res_pix,
	output logic               res_last
);

	gb3_pkg::column_t cols [3];

	logic [9:0]  vsum      [3][gb3_pkg::NUM_CHAN];
	logic [9:0]  vsum_s3   [3][gb3_pkg::NUM_CHAN];
	logic [11:0] hsum      [gb3_pkg::NUM_CHAN];
	logic [11:0] hsum_s4   [gb3_pkg::NUM_CHAN];
	logic [11:0] rq_s5     [gb3_pkg::NUM_CHAN];
	logic [11:0] cq        [gb3_pkg::NUM_CHAN];

	gb3_pkg::ctrl_t ctrl_s3, ctrl_s4, ctrl_s5;
	logic           valid_s3, valid_s4, valid_s5;

	assign cols[0] = col0;
	assign cols[1] = col1;
	assign cols[2] = col2;

	// vertical 1-2-1, rows outside the frame dropped
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < gb3_pkg::NUM_CHAN; k++) begin
				vsum[c][k] = (win_ctrl.top ? {2'b0, cols[c].top[k]} : 10'd0)
				           + {1'b0, cols[c].mid[k], 1'b0}
				           + (win_ctrl.bot ? {2'b0, cols[c].bot[k]} : 10'd0);
			end
		end
	end

	// horizontal 1-2-1, columns outside the frame dropped
	always_comb begin
		for (int k = 0; k < gb3_pkg::NUM_CHAN; k++) begin
			hsum[k] = (ctrl_s3.left ? {2'b0, vsum_s3[0][k]} : 12'd0)
			        + {1'b0, vsum_s3[1][k], 1'b0}
			        + (ctrl_s3.right ? {2'b0, vsum_s3[2][k]} : 12'd0);
		end
	end

	// the weight total factors into a row part and a column part
	always_ff @(posedge clk) begin
		if (adv) begin
			vsum_s3 <= vsum;
			hsum_s4 <= hsum;
			for (int k = 0; k < gb3_pkg::NUM_CHAN; k++) begin
				rq_s5[k] <= gb3_pkg::div_small(hsum_s4[k],
					gb3_pkg::divisor(ctrl_s4.top, ctrl_s4.bot));
			end
			ctrl_s3 <= win_ctrl;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= win_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_comb begin
		for (int k = 0; k < gb3_pkg::NUM_CHAN; k++) begin
			cq[k]      = gb3_pkg::div_small(rq_s5[k],
				gb3_pkg::divisor(ctrl_s5.left, ctrl_s5.right));
			res_pix[k] = cq[k][7:0];
		end
	end

	assign res_valid = valid_s5;
	assign res_last  = ctrl_s5.last;

endmodule

/* src/gaussian_blur_3x3_rgb.sv */
// 3x3 Gaussian blur (1-2-1 / 2-4-2 / 1-2-1) of an RGB pixel stream in raster order.
// Input channel: in_valid/in_stall with red_in, green_in, blue_in and padding.
// An item transfers at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with blurred channels and frame_end.
// Configuration: cfg_valid/cfg_ready write port, index 0 is image_width, index 1
// is image_height; write only while the block is idle. A write restarts the frame.
// Throughput: one item per clock while in_stall is low; the line store is one read
// and one write per cycle. The result for a pixel is due with the item that arrives
// one row plus one pixel later, and passes through the line store read, window shift,
// vertical sum, horizontal sum and two divide steps before it leaves on out_*.
// After the last pixel of a frame, image_width + 1 further items (padding or not)
// drive out the remaining results; frame_end marks the last one.
// Padding items within a frame transfer but do nothing.
// Reset clears counters, window and output; line stores hold no reset contents.
// A stalled receiver fills an output register and then a skid register; in_stall
// rises only once the skid register holds a result and falls when it drains.
module gaussian_blur_3x3_rgb #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gb3_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [gb3_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          red_in,
	input  logic [7:0]                          green_in,
	input  logic [7:0]                          blue_in,
	input  logic                                padding,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          red_out,
	output logic [7:0]                          green_out,
	output logic [7:0]                          blue_out,
	output logic                                frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [gb3_pkg::WIDTH_W-1:0]  width_q;
	logic [gb3_pkg::HEIGHT_W-1:0] height_q;
	logic                         cfg_we;

	logic [CW-1:0]                in_col_q;
	logic [gb3_pkg::IN_ROW_W-1:0] in_row_q;
	logic [CW-1:0]                out_col_q;
	logic [gb3_pkg::HEIGHT_W-1:0] out_row_q;

	logic [31:0]                  w_full;
	logic [CW:0]                  w_eff;
	logic [gb3_pkg::HEIGHT_W-1:0] h_eff;
	logic                         adv;
	logic                         flushing;
	logic                         take;
	logic                         col_wrap;
	gb3_pkg::pix_t                s0_pix;
	gb3_pkg::ctrl_t               s0_ctrl;
	logic                         s0_fwd;

	logic                         s1_valid;
	logic [CW-1:0]                s1_col;
	gb3_pkg::pix_t                s1_pix;
	gb3_pkg::ctrl_t               s1_ctrl;
	logic                         s1_fwd;
	gb3_pkg::entry_t              s1_fwd_ent;
	gb3_pkg::entry_t              rd_ent;
	gb3_pkg::entry_t              s1_ent;
	gb3_pkg::entry_t              wr_ent;
	gb3_pkg::column_t             new_col;
	logic                         win_shift;

	gb3_pkg::column_t             win0, win1, win2;
	logic                         valid_s2;
	gb3_pkg::ctrl_t               ctrl_s2;

	logic                         res_valid;
	gb3_pkg::pix_t                res_pix;
	logic                         res_last;

	logic                         out_valid_q;
	gb3_pkg::pix_t                out_pix_q;
	logic                         out_last_q;
	logic                         skid_valid_q;
	gb3_pkg::pix_t                skid_pix_q;
	logic                         skid_last_q;
	logic                         out_take;

	// configuration
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gb3_pkg::WIDTH_RESET;
			height_q <= gb3_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gb3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[gb3_pkg::WIDTH_W-1:0];
				gb3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_full = 32'd1;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_full = 32'(MAX_WIDTH);
		end else begin
			w_full = 32'(width_q);
		end
		w_eff = w_full[CW:0];
		h_eff = (height_q == '0) ? gb3_pkg::HEIGHT_W'(1) : height_q;
	end

	// stage 0: counters and per-position control
	assign adv      = ~skid_valid_q;
	assign in_stall = skid_valid_q;

	always_comb begin
		flushing = in_row_q >= {1'b0, h_eff};
		take     = in_valid & adv & (flushing | ~padding);
		s0_pix   = flushing ? '0 : {red_in, green_in, blue_in};
		col_wrap = ({1'b0, in_col_q} + (CW+1)'(1)) >= w_eff;

		s0_ctrl.emit  = (in_row_q >= gb3_pkg::IN_ROW_W'(2))
		              || (in_row_q == gb3_pkg::IN_ROW_W'(1) && in_col_q != '0);
		s0_ctrl.top   = out_row_q != '0;
		s0_ctrl.bot   = ({1'b0, out_row_q} + gb3_pkg::IN_ROW_W'(1)) < {1'b0, h_eff};
		s0_ctrl.left  = out_col_q != '0;
		s0_ctrl.right = ({1'b0, out_col_q} + (CW+1)'(1)) < w_eff;
		s0_ctrl.last  = ~s0_ctrl.bot & ~s0_ctrl.right;

		// the item in stage 1 writes this column in the same cycle
		s0_fwd = s1_valid & (s1_col == in_col_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (s0_ctrl.emit && s0_ctrl.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + gb3_pkg::IN_ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				if (s0_ctrl.emit) begin
					if (s0_ctrl.right) begin
						out_col_q <= out_col_q + CW'(1);
					end else begin
						out_col_q <= '0;
						out_row_q <= out_row_q + gb3_pkg::HEIGHT_W'(1);
					end
				end
			end
		end
	end

	// stage 1: line store read data, store update, window input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (adv) begin
			s1_valid <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_col     <= in_col_q;
			s1_pix     <= s0_pix;
			s1_ctrl    <= s0_ctrl;
			s1_fwd     <= s0_fwd;
			s1_fwd_ent <= wr_ent;
		end
	end

	gb3_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (in_col_q),
		.rd_data (rd_ent),
		.wr_en   (win_shift),
		.wr_addr (s1_col),
		.wr_data (wr_ent)
	);

	always_comb begin
		s1_ent         = s1_fwd ? s1_fwd_ent : rd_ent;
		wr_ent.upper   = s1_ent.middle;
		wr_ent.middle  = s1_pix;
		new_col.top    = s1_ent.upper;
		new_col.mid    = s1_ent.middle;
		new_col.bot    = s1_pix;
		win_shift      = adv & s1_valid;
	end

	// stage 2: window as a chain of column cells, newest on the right
	gb3_win_cell u_cell2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (win_shift),
		.col_in  (new_col),
		.col_out (win2)
	);

	gb3_win_cell u_cell1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (win_shift),
		.col_in  (win2),
		.col_out (win1)
	);

	gb3_win_cell u_cell0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (win_shift),
		.col_in  (win1),
		.col_out (win0)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= s1_valid & s1_ctrl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s2 <= s1_ctrl;
		end
	end

	gb3_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.win_valid (valid_s2),
		.win_ctrl  (ctrl_s2),
		.col0      (win0),
		.col1      (win1),
		.col2      (win2),
		.res_valid (res_valid),
		.res_pix   (res_pix),
		.res_last  (res_last)
	);

	// output register plus skid register
	assign out_take = out_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_pix_q  <= skid_pix_q;
				out_last_q <= skid_last_q;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_take) begin
				skid_pix_q  <= res_pix;
				skid_last_q <= res_last;
			end else begin
				out_pix_q  <= res_pix;
				out_last_q <= res_last;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = out_pix_q[2];
	assign green_out = out_pix_q[1];
	assign blue_out  = out_pix_q[0];
	assign frame_end = out_last_q;

endmodule

/* verif/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH  = 1024;
	localparam int SETTLE      = 16;
	localparam int CALM_TAIL   = 300;
	localparam int ITEM_BUDGET = 1450;
	localparam int MAX_REPORTS = 10;

	typedef enum logic [1:0] {OP_PIXEL, OP_CONFIG, OP_DRAIN} stim_kind_t;

	typedef struct {
		stim_kind_t                      kind;
		gb3_pkg::pix_t                   px;
		logic                            pad;
		logic [gb3_pkg::CFG_INDEX_W-1:0] index;
		logic [gb3_pkg::CFG_DATA_W-1:0]  data;
	} stim_op_t;

	typedef struct packed {
		gb3_pkg::pix_t px;
		logic          last;
	} blur_result_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [gb3_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [gb3_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	logic [7:0]                      red_in    = '0;
	logic [7:0]                      green_in  = '0;
	logic [7:0]                      blue_in   = '0;
	logic                            padding   = 1'b0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [7:0]                      red_out;
	logic [7:0]                      green_out;
	logic [7:0]                      blue_out;
	logic                            frame_end;

	gaussian_blur_3x3_rgb #(.MAX_WIDTH(LINE_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.padding   (padding),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.frame_end (frame_end)
	);

	// blur predictor state
	logic [gb3_pkg::WIDTH_W-1:0]  width_reg  = gb3_pkg::WIDTH_RESET;
	logic [gb3_pkg::HEIGHT_W-1:0] height_reg = gb3_pkg::HEIGHT_RESET;
	gb3_pkg::pix_t                upper_line [LINE_DEPTH] = '{default: '0};
	gb3_pkg::pix_t                middle_line [LINE_DEPTH] = '{default: '0};
	gb3_pkg::pix_t                win [3][3] = '{default: '0};
	int unsigned                  in_col  = 0;
	int unsigned                  in_row  = 0;
	int unsigned                  out_col = 0;
	int unsigned                  out_row = 0;

	stim_op_t     pending_q [$];
	blur_result_t expected_q [$];
	int unsigned  pushed       = 0;
	int           errors       = 0;
	int           quiet_cycles = 0;
	int           gap_left     = 0;
	int           stall_left   = 0;
	logic         calm         = 1'b0;
	logic         in_noisy     = 1'b1;
	logic         out_noisy    = 1'b1;

	function automatic int unsigned eff_width(logic [gb3_pkg::WIDTH_W-1:0] v);
		if (v == '0)
			return 32'd1;
		if (32'(v) > LINE_DEPTH)
			return LINE_DEPTH;
		return 32'(v);
	endfunction

	function automatic int unsigned eff_height(logic [gb3_pkg::HEIGHT_W-1:0] v);
		return (v == '0) ? 32'd1 : 32'(v);
	endfunction

	function automatic void restart_frame();
		in_col  = 0;
		in_row  = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	// Advance the window by one item; return 1 when a blurred pixel is due.
	function automatic bit blur_step(input gb3_pkg::pix_t px_in, input logic pad,
			output blur_result_t res);
		int unsigned   w, h, col, wsum, wt;
		int unsigned   sums [3];
		int            yr, xc, r, c, k;
		gb3_pkg::pix_t px, up, mid;
		bit            emit;
		res = '0;
		w = eff_width(width_reg);
		h = eff_height(height_reg);
		px = '0;
		if (in_row < h) begin
			if (pad)
				return 1'b0;
			px = px_in;
		end
		// once the frame input is complete every item flushes and its pixel is dropped
		emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		col = in_col % LINE_DEPTH;
		up = upper_line[col];
		mid = middle_line[col];
		upper_line[col] = mid;
		middle_line[col] = px;
		for (r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = up;
		win[1][2] = mid;
		win[2][2] = px;
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (!emit)
			return 1'b0;

		sums = '{0, 0, 0};
		wsum = 0;
		for (r = 0; r < 3; r++) begin
			for (c = 0; c < 3; c++) begin
				yr = int'(out_row) + r - 1;
				xc = int'(out_col) + c - 1;
				// leave out neighbors beyond the image border
				if (yr >= 0 && yr < int'(h) && xc >= 0 && xc < int'(w)) begin
					wt = (r == 1 ? 2 : 1) * (c == 1 ? 2 : 1);
					wsum += wt;
					for (k = 0; k < gb3_pkg::NUM_CHAN; k++)
						sums[k] += wt * win[r][c][k];
				end
			end
		end
		if (wsum == 0)
			wsum = 1;
		for (k = 0; k < gb3_pkg::NUM_CHAN; k++)
			res.px[k] = 8'(sums[k] / wsum);
		res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
		if (res.last) begin
			restart_frame();
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
		return 1'b1;
	endfunction

	function automatic gb3_pkg::pix_t rand_pixel();
		gb3_pkg::pix_t p;
		int            k;
		for (k = 0; k < gb3_pkg::NUM_CHAN; k++) begin
			case ($urandom_range(0, 7))
				0: p[k] = 8'h00;
				1: p[k] = 8'hff;
				default: p[k] = 8'($urandom);
			endcase
		end
		return p;
	endfunction

	function automatic void push_pixel(gb3_pkg::pix_t px, logic pad);
		stim_op_t op;
		op = '{kind: OP_PIXEL, px: px, pad: pad, index: '0, data: '0};
		pending_q.push_back(op);
		pushed++;
	endfunction

	function automatic void push_config(logic [gb3_pkg::CFG_INDEX_W-1:0] index,
			logic [gb3_pkg::CFG_DATA_W-1:0] data);
		stim_op_t op;
		op = '{kind: OP_CONFIG, px: '0, pad: 1'b0, index: index, data: data};
		pending_q.push_back(op);
	endfunction

	function automatic void push_drain();
		stim_op_t op;
		op = '{kind: OP_DRAIN, px: '0, pad: 1'b0, index: '0, data: '0};
		pending_q.push_back(op);
	endfunction

	// One full frame plus its flush items.
	function automatic void push_frame(int unsigned w, int unsigned h);
		int unsigned i;
		for (i = 0; i < w * h; i++) begin
			if ($urandom_range(0, 7) == 0)
				push_pixel(rand_pixel(), 1'b1);
			push_pixel(rand_pixel(), 1'b0);
		end
		for (i = 0; i <= w; i++)
			push_pixel(rand_pixel(), 1'($urandom_range(0, 1)));
	endfunction

	initial begin
		forever #5ns clk = ~clk;
	end

	initial begin
		#4_000_000ns;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// driver: one op at a time, held while stalled
	always @(posedge clk) begin
		stim_op_t op;
		if (arst_n) begin
			if ((in_valid && in_stall) || (cfg_valid && !cfg_ready)) begin
				// hold the stalled transfer
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				cfg_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_q.size() == 0) begin
				in_valid <= 1'b0;
				cfg_valid <= 1'b0;
			end else if (!calm && in_noisy && $urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				cfg_valid <= 1'b0;
				gap_left <= $urandom_range(0, 2);
			end else begin
				op = pending_q[0];
				case (op.kind)
					OP_PIXEL: begin
						void'(pending_q.pop_front());
						in_valid <= 1'b1;
						red_in <= op.px[2];
						green_in <= op.px[1];
						blue_in <= op.px[0];
						padding <= op.pad;
						cfg_valid <= 1'b0;
					end
					OP_CONFIG: begin
						// write only once the pipeline has drained
						if (quiet_cycles >= SETTLE) begin
							void'(pending_q.pop_front());
							cfg_valid <= 1'b1;
							cfg_index <= op.index;
							cfg_data <= op.data;
						end else begin
							cfg_valid <= 1'b0;
						end
						in_valid <= 1'b0;
					end
					default: begin
						if (quiet_cycles >= 1)
							void'(pending_q.pop_front());
						in_valid <= 1'b0;
						cfg_valid <= 1'b0;
					end
				endcase
			end
			calm <= (pending_q.size() < CALM_TAIL);
			if ($urandom_range(0, 99) == 0)
				in_noisy <= !in_noisy;
		end
	end

	// monitor: check results, predict on each transfer, drive output stalls
	always @(posedge clk) begin
		blur_result_t got, want, res;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.px = {red_out, green_out, blue_out};
				got.last = frame_end;
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected result r=%0d g=%0d b=%0d frame_end=%0b",
							$time, red_out, green_out, blue_out, frame_end);
				end else begin
					want = expected_q.pop_front();
					if (got != want) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display({"%0t: mismatch expected r=%0d g=%0d b=%0d frame_end=%0b,",
								" got r=%0d g=%0d b=%0d frame_end=%0b"}, $time,
								want.px[2], want.px[1], want.px[0], want.last,
								got.px[2], got.px[1], got.px[0], got.last);
					end
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gb3_pkg::REG_IMAGE_WIDTH:
						width_reg = cfg_data[gb3_pkg::WIDTH_W-1:0];
					gb3_pkg::REG_IMAGE_HEIGHT:
						height_reg = cfg_data[gb3_pkg::HEIGHT_W-1:0];
					default: ;
				endcase
				restart_frame();
			end

			if (in_valid && !in_stall) begin
				if (blur_step({red_in, green_in, blue_in}, padding, res))
					expected_q.push_back(res);
			end

			if (in_valid || cfg_valid || expected_q.size() != 0)
				quiet_cycles <= 0;
			else if (quiet_cycles < SETTLE)
				quiet_cycles <= quiet_cycles + 1;

			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (!calm && out_noisy && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b0;
			end
			if ($urandom_range(0, 99) == 0)
				out_noisy <= !out_noisy;
		end
	end

	initial begin
		logic [gb3_pkg::CFG_DATA_W-1:0] w_data, h_data;
		int unsigned                    w, h, phase, frames, f, n, i;

		// a small real frame: extremes, padding inside the frame, pixels while flushing
		push_config(gb3_pkg::REG_IMAGE_WIDTH, 13'd3);
		push_config(gb3_pkg::REG_IMAGE_HEIGHT, 13'd2);
		push_pixel({8'h00, 8'h00, 8'h00}, 1'b0);
		push_pixel({8'hff, 8'hff, 8'hff}, 1'b0);
		push_pixel({8'hff, 8'h00, 8'hff}, 1'b0);
		push_pixel({8'h55, 8'haa, 8'h12}, 1'b1);
		push_pixel({8'h00, 8'hff, 8'h00}, 1'b0);
		push_pixel({8'hff, 8'hff, 8'hff}, 1'b0);
		push_pixel({8'h00, 8'h00, 8'h00}, 1'b0);
		push_pixel({8'hff, 8'hff, 8'hff}, 1'b0);
		push_pixel({8'h00, 8'h00, 8'h00}, 1'b1);
		push_pixel({8'hff, 8'h00, 8'h00}, 1'b0);
		push_pixel({8'hff, 8'hff, 8'hff}, 1'b1);
		push_drain();
		// zero registers act as one pixel
		push_config(gb3_pkg::REG_IMAGE_WIDTH, 13'd0);
		push_config(gb3_pkg::REG_IMAGE_HEIGHT, 13'd0);
		push_pixel({8'hff, 8'h80, 8'h01}, 1'b0);
		push_pixel({8'h00, 8'h00, 8'h00}, 1'b1);
		push_pixel({8'hff, 8'hff, 8'hff}, 1'b0);
		// part of a frame, cut off by the next register write
		push_config(gb3_pkg::REG_IMAGE_WIDTH, 13'd4);
		push_config(gb3_pkg::REG_IMAGE_HEIGHT, 13'd3);
		for (i = 0; i < 5; i++)
			push_pixel(rand_pixel(), 1'b0);
		// width clamps to the line store depth: the first result comes only if
		// the row wraps there, then the frame is cut off
		push_config(gb3_pkg::REG_IMAGE_WIDTH, 13'h1fff);
		push_config(gb3_pkg::REG_IMAGE_HEIGHT, 13'd1);
		for (i = 0; i < LINE_DEPTH + 2; i++)
			push_pixel(rand_pixel(), 1'b0);

		phase = 0;
		h_data = 13'd1;
		while (pushed < ITEM_BUDGET) begin
			case (phase)
				3: begin
					// one column, many rows
					w_data = 13'd1;
					h_data = 13'd100;
				end
				default: begin
					if ($urandom_range(0, 9) == 0)
						w_data = 13'($urandom_range(1, 40));
					else
						w_data = 13'($urandom_range(1, 10));
					if ($urandom_range(0, 15) == 0)
						w_data = 13'd0;
					// upper bits beyond the width register are dropped
					if ($urandom_range(0, 7) == 0)
						w_data[gb3_pkg::CFG_DATA_W-1:gb3_pkg::WIDTH_W] = 2'($urandom);
					if ($urandom_range(0, 3) != 0 || phase < 2) begin
						if ($urandom_range(0, 9) == 0)
							h_data = 13'($urandom_range(1, 12));
						else
							h_data = 13'($urandom_range(1, 6));
						if ($urandom_range(0, 15) == 0)
							h_data = 13'd0;
					end
				end
			endcase
			push_config(gb3_pkg::REG_IMAGE_WIDTH, w_data);
			push_config(gb3_pkg::REG_IMAGE_HEIGHT, h_data);
			w = eff_width(w_data[gb3_pkg::WIDTH_W-1:0]);
			h = eff_height(h_data);
			frames = (phase == 3) ? 1 : $urandom_range(1, 3);
			for (f = 0; f < frames; f++) begin
				push_frame(w, h);
				if ($urandom_range(0, 5) == 0)
					push_drain();
			end
			if (phase != 3 && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, w * h);
				for (i = 0; i < n; i++)
					push_pixel(rand_pixel(), 1'b0);
			end
			phase++;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_q.size() != 0 || in_valid || cfg_valid);
		for (i = 0; i < 100000 && expected_q.size() != 0; i++)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (expected_q.size() != 0) begin
			errors += expected_q.size();
			$display("%0d expected results never arrived", expected_q.size());
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
src/gb3_pkg.sv
src/gb3_line_store.sv
src/gb3_win_cell.sv
src/gb3_filter.sv
src/gaussian_blur_3x3_rgb.sv
verif/tb_top.sv
